[rtl/mbpf_pkg.sv]
// Shared types, codes and helpers for the monochrome bitmap fill engine.
// No dependencies; used by mbpf_mul and mono_bitmap_pattern_fill.

package mbpf_pkg;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_RECT_COPY = 2'd0,
        OP_RECT_XOR  = 2'd1,
        OP_ELLIPSE   = 2'd2,
        OP_READ      = 2'd3
    } t_op;

    // Configuration register indexes
    localparam logic [1:0] REG_CLIP_TOP    = 2'd0;
    localparam logic [1:0] REG_CLIP_LEFT   = 2'd1;
    localparam logic [1:0] REG_CLIP_BOTTOM = 2'd2;
    localparam logic [1:0] REG_CLIP_RIGHT  = 2'd3;

    // Internal signed coordinate, wide enough for every sum of two inputs
    localparam int CW = 22;
    typedef logic signed [CW-1:0] t_coord;

    // Multiplier operand and product widths
    localparam int MW = 32;
    typedef logic [MW-1:0]   t_mop;
    typedef logic [2*MW-1:0] t_prod;

    // Multiplier handshake between the sequencer and the multiplier
    typedef struct packed {
        logic start;
        t_mop a;
        t_mop b;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_prod product;
    } t_mul_rsp;

    // Pattern byte for a row: low three bits of the row pick the byte
    function automatic logic [7:0] pat_byte(input logic [63:0] pat, input logic [2:0] idx);
        pat_byte = pat[{idx, 3'b000} +: 8];
    endfunction

endpackage

[rtl/mbpf_mul.sv]
// Sequential unsigned multiplier, one multiplier bit per cycle.
// Depends on mbpf_pkg for operand and handshake types.

module mbpf_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbpf_pkg::t_mul_req i_req,
    output mbpf_pkg::t_mul_rsp o_rsp
);

    localparam int CNTW = $clog2(mbpf_pkg::MW);

    logic                  r_busy;
    logic                  r_done;
    logic [CNTW-1:0]       r_cnt;
    mbpf_pkg::t_prod       r_acc;
    mbpf_pkg::t_prod       r_mcand;
    mbpf_pkg::t_mop        r_mplier;

    // Shift-and-add: add the shifted multiplicand when the low bit is set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_acc    <= '0;
                r_mcand  <= {{mbpf_pkg::MW{1'b0}}, i_req.a};
                r_mplier <= i_req.b;
            end else if (r_busy) begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(mbpf_pkg::MW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

[rtl/mono_bitmap_pattern_fill.sv]
// Top level of the monochrome bitmap pattern fill engine.
// Depends on mbpf_pkg and mbpf_mul.

// A 1-bit-per-pixel frame buffer (leftmost pixel in the byte MSB) held in one
// synchronous RAM. After reset the block clears the buffer, one byte per cycle;
// o_stall is high during that pass while configuration writes are still taken.
// Every item returns exactly one result: the byte for a read, zero for a fill.
// A rectangle fill reads each buffer byte touched after clipping, then modifies
// and writes it back through the single RAM port. An ellipse fill first computes
// set-up products, then per row a starting offset and a series of inequality
// tests, each test being two passes through the shift-add multiplier, plus the
// span writes as for a rectangle. One item is worked on at a time; the next is
// taken while the previous result waits on the output.

module mono_bitmap_pattern_fill #(
    parameter int SCREEN_WIDTH  = 512,
    parameter int SCREEN_HEIGHT = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_rect_top,
    input  logic [15:0] i_rect_left,
    input  logic [15:0] i_rect_bottom,
    input  logic [15:0] i_rect_right,
    input  logic [63:0] i_fill_pattern,
    input  logic [14:0] i_byte_address,
    // Result item channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
    localparam int FB_BYTES  = ROW_BYTES * SCREEN_HEIGHT;
    localparam int AW        = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
    localparam int BW        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int XW        = $clog2(SCREEN_WIDTH + 1);
    localparam int RW        = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int CW        = mbpf_pkg::CW;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD, S_RD_DATA, S_DONE,
        S_RECT_ROW,
        S_EL_CENTRE, S_EL_HH, S_EL_WW, S_EL_HHWW, S_EL_ROWS,
        S_EL_ROW, S_EL_RW2, S_EL_TEST0, S_EL_OFF, S_EL_OFF2, S_EL_CMP,
        S_EL_SPAN1, S_EL_SPAN2, S_EL_NEXT,
        S_MUL_WAIT, S_SPAN_CLIP, S_SPAN_RD, S_SPAN_WR
    } t_state;

    // Control state
    t_state          r_state;
    t_state          r_ret;
    t_state          r_mret;
    logic [AW-1:0]   r_clr;
    logic            r_out_valid;
    logic [7:0]      r_out_data;
    logic [9:0]      r_clip_top, r_clip_left, r_clip_bottom, r_clip_right;

    // Item payload and work registers
    mbpf_pkg::t_op   r_op;
    logic [63:0]     r_pat;
    logic [14:0]     r_addr;
    logic [7:0]      r_res;
    mbpf_pkg::t_coord r_left, r_right, r_row, r_rend;
    mbpf_pkg::t_coord r_hhh, r_absw, r_ox, r_oy;
    mbpf_pkg::t_coord r_last, r_slope, r_off;
    mbpf_pkg::t_prod r_hh, r_ww, r_hhww, r_rowterm;

    // Span engine registers
    mbpf_pkg::t_coord r_sp_row, r_sp_start, r_sp_end;
    logic [7:0]      r_sp_pat;
    logic            r_sp_xor;
    logic [XW-1:0]   r_cs, r_ce;
    logic [BW-1:0]   r_b, r_blast;
    logic [AW-1:0]   r_rowbase;

    // Frame buffer
    logic [7:0]      r_fb [FB_BYTES];
    logic [7:0]      r_rdata;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]      mem_wdata;

    // Multiplier
    mbpf_pkg::t_mul_req r_mul;
    mbpf_pkg::t_mul_rsp mul_rsp;

    mbpf_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_mul),
        .o_rsp  (mul_rsp)
    );

    // Accept and configuration strobes
    logic in_acc, cfg_wr;
    assign in_acc = i_valid && !o_stall;
    assign cfg_wr = psel && penable && pwrite;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign pready = 1'b1;

    // Register readback
    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            mbpf_pkg::REG_CLIP_TOP:    prdata = {22'd0, r_clip_top};
            mbpf_pkg::REG_CLIP_LEFT:   prdata = {22'd0, r_clip_left};
            mbpf_pkg::REG_CLIP_BOTTOM: prdata = {22'd0, r_clip_bottom};
            mbpf_pkg::REG_CLIP_RIGHT:  prdata = {22'd0, r_clip_right};
            default:                   prdata = '0;
        endcase
    end

    // Input coordinates, sign-extended
    mbpf_pkg::t_coord in_top, in_left, in_bottom, in_right, in_dw, in_dh, in_hw, in_hhh;
    always_comb begin
        in_top    = CW'($signed(i_rect_top));
        in_left   = CW'($signed(i_rect_left));
        in_bottom = CW'($signed(i_rect_bottom));
        in_right  = CW'($signed(i_rect_right));
        in_dw     = in_right - in_left;
        in_dh     = in_bottom - in_top;
        // halve with truncation toward zero
        in_hw     = $signed(in_dw + CW'({1'b0, in_dw[CW-1]})) >>> 1;
        in_hhh    = $signed(in_dh + CW'({1'b0, in_dh[CW-1]})) >>> 1;
    end

    // Span clipping against the clip registers and the screen
    mbpf_pkg::t_coord c_top, c_left, c_bot, c_right, s1, s2, e1, e2;
    logic row_ok, span_empty;
    always_comb begin
        c_top   = {{(CW-10){1'b0}}, r_clip_top};
        c_left  = {{(CW-10){1'b0}}, r_clip_left};
        c_bot   = {{(CW-10){1'b0}}, r_clip_bottom};
        c_right = {{(CW-10){1'b0}}, r_clip_right};
        row_ok  = (r_sp_row >= c_top) && (r_sp_row < c_bot) && (r_sp_row >= 0)
               && (r_sp_row < CW'(SCREEN_HEIGHT));
        s1 = (r_sp_start < c_left) ? c_left : r_sp_start;
        s2 = (s1 < 0) ? '0 : s1;
        e1 = (r_sp_end > c_right) ? c_right : r_sp_end;
        e2 = (e1 > CW'(SCREEN_WIDTH)) ? CW'(SCREEN_WIDTH) : e1;
        span_empty = !row_ok || (s2 >= e2);
    end

    // Byte mask for the current span byte
    logic [2:0]    lo;
    logic [3:0]    hi;
    logic [XW-1:0] ce_m1;
    logic [7:0]    mask;
    always_comb begin
        ce_m1 = r_ce - 1'b1;
        lo    = (r_b == BW'(r_cs >> 3)) ? r_cs[2:0] : 3'd0;
        hi    = (r_b == r_blast) ? ({1'b0, ce_m1[2:0]} + 4'd1) : 4'd8;
        mask  = (8'hFF >> lo) & ~(8'hFF >> hi);
    end

    // RAM port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_rowbase + AW'(r_b);
        mem_wdata = r_sp_xor ? (r_rdata ^ (mask & r_sp_pat))
                             : ((r_rdata & ~mask) | (mask & r_sp_pat));
        mem_raddr = r_rowbase + AW'(r_b);
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = 8'd0;
        end else if (r_state == S_SPAN_WR) begin
            mem_we = 1'b1;
        end
        if (r_state == S_RD) begin
            mem_raddr = AW'(r_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fb[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_fb[mem_raddr];
    end

    // Ellipse per-row helpers
    mbpf_pkg::t_coord off_try, sum_test;
    mbpf_pkg::t_prod  test_lhs;
    always_comb begin
        off_try  = r_last - r_slope + CW'(1);
        sum_test = r_oy + r_row;
        test_lhs = mul_rsp.product + r_rowterm;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_ret         <= S_IDLE;
            r_mret        <= S_IDLE;
            r_clr         <= '0;
            r_out_valid   <= 1'b0;
            r_clip_top    <= 10'd0;
            r_clip_left   <= 10'd0;
            r_clip_bottom <= 10'd512;
            r_clip_right  <= 10'd512;
            r_mul.start   <= 1'b0;
        end else begin
            // S_DONE handles the output register itself
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                case (paddr[3:2])
                    mbpf_pkg::REG_CLIP_TOP:    r_clip_top    <= pwdata[9:0];
                    mbpf_pkg::REG_CLIP_LEFT:   r_clip_left   <= pwdata[9:0];
                    mbpf_pkg::REG_CLIP_BOTTOM: r_clip_bottom <= pwdata[9:0];
                    mbpf_pkg::REG_CLIP_RIGHT:  r_clip_right  <= pwdata[9:0];
                    default: ;
                endcase
            end

            case (r_state)
                // Zero the buffer after reset
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(FB_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end

                // Take an item
                S_IDLE: begin
                    if (in_acc) begin
                        r_op    <= mbpf_pkg::t_op'(i_operation);
                        r_pat   <= i_fill_pattern;
                        r_addr  <= i_byte_address;
                        r_res   <= 8'd0;
                        r_left  <= in_left;
                        r_right <= in_right;
                        r_hhh   <= in_hhh;
                        r_absw  <= in_hw[CW-1] ? -in_hw : in_hw;
                        r_ox    <= in_left + in_hw;
                        r_oy    <= in_top + in_hhh;
                        r_last  <= in_hw;
                        r_slope <= '0;
                        r_row   <= (in_top < 0) ? '0 : in_top;
                        r_rend  <= (in_bottom > CW'(SCREEN_HEIGHT)) ? CW'(SCREEN_HEIGHT)
                                                                     : in_bottom;
                        case (mbpf_pkg::t_op'(i_operation))
                            mbpf_pkg::OP_RECT_COPY: r_state <= S_RECT_ROW;
                            mbpf_pkg::OP_RECT_XOR:  r_state <= S_RECT_ROW;
                            mbpf_pkg::OP_ELLIPSE:   r_state <= S_EL_CENTRE;
                            default:                r_state <= S_RD;
                        endcase
                    end
                end

                // Byte read
                S_RD: r_state <= S_RD_DATA;
                S_RD_DATA: begin
                    r_res   <= ({17'd0, r_addr} < 32'(FB_BYTES)) ? r_rdata : 8'd0;
                    r_state <= S_DONE;
                end

                // Deliver the result once the output register is free
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end

                // Rectangle: one span per row
                S_RECT_ROW: begin
                    if (r_row >= r_rend) begin
                        r_state <= S_DONE;
                    end else begin
                        r_sp_row   <= r_row;
                        r_sp_start <= r_left;
                        r_sp_end   <= r_right;
                        r_sp_pat   <= mbpf_pkg::pat_byte(r_pat, r_row[2:0]);
                        r_sp_xor   <= (r_op == mbpf_pkg::OP_RECT_XOR);
                        r_row      <= r_row + CW'(1);
                        r_ret      <= S_RECT_ROW;
                        r_state    <= S_SPAN_CLIP;
                    end
                end

                // Ellipse centre row spans the whole width
                S_EL_CENTRE: begin
                    r_sp_row   <= r_oy;
                    r_sp_start <= r_left;
                    r_sp_end   <= r_right;
                    r_sp_pat   <= mbpf_pkg::pat_byte(r_pat, r_hhh[2:0]);
                    r_sp_xor   <= 1'b0;
                    r_ret      <= S_EL_HH;
                    r_state    <= S_SPAN_CLIP;
                end

                // Set-up products hh, ww, hh*ww
                S_EL_HH: begin
                    if (r_hhh < CW'(1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_mul.start <= 1'b1;
                        r_mul.a     <= 32'(r_hhh);
                        r_mul.b     <= 32'(r_hhh);
                        r_mret      <= S_EL_WW;
                        r_state     <= S_MUL_WAIT;
                    end
                end
                S_EL_WW: begin
                    r_hh        <= mul_rsp.product;
                    r_mul.start <= 1'b1;
                    r_mul.a     <= 32'(r_absw);
                    r_mul.b     <= 32'(r_absw);
                    r_mret      <= S_EL_HHWW;
                    r_state     <= S_MUL_WAIT;
                end
                S_EL_HHWW: begin
                    r_ww        <= mul_rsp.product;
                    r_mul.start <= 1'b1;
                    r_mul.a     <= r_hh[31:0];
                    r_mul.b     <= mul_rsp.product[31:0];
                    r_mret      <= S_EL_ROWS;
                    r_state     <= S_MUL_WAIT;
                end
                S_EL_ROWS: begin
                    r_hhww  <= mul_rsp.product;
                    r_row   <= CW'(1);
                    r_state <= S_EL_ROW;
                end

                // Per row: starting offset and row*row*ww
                S_EL_ROW: begin
                    if (r_row > r_hhh) begin
                        r_state <= S_DONE;
                    end else if ((r_oy - r_row < 0) && (sum_test >= CW'(SCREEN_HEIGHT))) begin
                        r_state <= S_DONE;
                    end else begin
                        r_off       <= (off_try > r_absw) ? r_absw : off_try;
                        r_mul.start <= 1'b1;
                        r_mul.a     <= 32'(r_row);
                        r_mul.b     <= 32'(r_row);
                        r_mret      <= S_EL_RW2;
                        r_state     <= S_MUL_WAIT;
                    end
                end
                S_EL_RW2: begin
                    r_mul.start <= 1'b1;
                    r_mul.a     <= mul_rsp.product[31:0];
                    r_mul.b     <= r_ww[31:0];
                    r_mret      <= S_EL_TEST0;
                    r_state     <= S_MUL_WAIT;
                end
                S_EL_TEST0: begin
                    r_rowterm <= mul_rsp.product;
                    r_state   <= S_EL_OFF;
                end

                // Walk the offset down until the point is inside
                S_EL_OFF: begin
                    if (r_off <= 0) begin
                        r_state <= S_EL_SPAN1;
                    end else begin
                        r_mul.start <= 1'b1;
                        r_mul.a     <= 32'(r_off);
                        r_mul.b     <= 32'(r_off);
                        r_mret      <= S_EL_OFF2;
                        r_state     <= S_MUL_WAIT;
                    end
                end
                S_EL_OFF2: begin
                    r_mul.start <= 1'b1;
                    r_mul.a     <= mul_rsp.product[31:0];
                    r_mul.b     <= r_hh[31:0];
                    r_mret      <= S_EL_CMP;
                    r_state     <= S_MUL_WAIT;
                end
                S_EL_CMP: begin
                    if (test_lhs <= r_hhww) begin
                        r_state <= S_EL_SPAN1;
                    end else begin
                        r_off   <= r_off - CW'(1);
                        r_state <= S_EL_OFF;
                    end
                end

                // Mirrored spans above and below the centre
                S_EL_SPAN1: begin
                    r_sp_row   <= r_oy - r_row;
                    r_sp_start <= r_ox - r_off;
                    r_sp_end   <= r_ox + r_off;
                    r_sp_pat   <= mbpf_pkg::pat_byte(r_pat, r_hhh[2:0] - r_row[2:0]);
                    r_sp_xor   <= 1'b0;
                    r_ret      <= S_EL_SPAN2;
                    r_state    <= S_SPAN_CLIP;
                end
                S_EL_SPAN2: begin
                    r_sp_row <= r_oy + r_row;
                    r_sp_pat <= mbpf_pkg::pat_byte(r_pat, r_hhh[2:0] + r_row[2:0]);
                    r_ret    <= S_EL_NEXT;
                    r_state  <= S_SPAN_CLIP;
                end
                S_EL_NEXT: begin
                    r_slope <= r_last - r_off;
                    r_last  <= r_off;
                    r_row   <= r_row + CW'(1);
                    r_state <= S_EL_ROW;
                end

                // Start pulse lasts one cycle
                S_MUL_WAIT: begin
                    r_mul.start <= 1'b0;
                    if (mul_rsp.done) begin
                        r_state <= r_mret;
                    end
                end

                // Span engine: clip, then read-modify-write each byte
                S_SPAN_CLIP: begin
                    if (span_empty) begin
                        r_state <= r_ret;
                    end else begin
                        r_cs      <= XW'(s2);
                        r_ce      <= XW'(e2);
                        r_b       <= BW'(s2 >>> 3);
                        r_blast   <= BW'((e2 - CW'(1)) >>> 3);
                        r_rowbase <= AW'(r_sp_row[RW-1:0] * ROW_BYTES);
                        r_state   <= S_SPAN_RD;
                    end
                end
                S_SPAN_RD: r_state <= S_SPAN_WR;
                S_SPAN_WR: begin
                    if (r_b == r_blast) begin
                        r_state <= r_ret;
                    end else begin
                        r_b     <= r_b + 1'b1;
                        r_state <= S_SPAN_RD;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("buffer written while idle");

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPAN_WR) |-> ($past(r_state) == S_SPAN_RD))
        else $error("span write without a preceding read");

    a_byte_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPAN_RD || r_state == S_SPAN_WR) |-> (r_b <= r_blast))
        else $error("span byte index past last byte");

    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_op != mbpf_pkg::OP_READ) |-> (r_res == 8'd0))
        else $error("fill result not zero");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for mono_bitmap_pattern_fill: pattern rect/ellipse fills and byte reads.
// Depends on mbpf_pkg and the RTL; keeps its own frame buffer copy to predict read bytes.
`timescale 1ns / 1ps

module tb_top;

    localparam int SCR_W     = 512;
    localparam int SCR_H     = 512;
    localparam int ROW_B     = SCR_W / 8;
    localparam int FB_SIZE   = ROW_B * SCR_H;
    localparam int IDLE_LIMIT = 2000000;

    typedef struct {
        mbpf_pkg::t_op    op;
        logic signed [15:0] top, left, bottom, right;
        logic [63:0]      pat;
        logic [14:0]      addr;
    } t_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_operation = '0;
    logic [15:0] i_rect_top = '0, i_rect_left = '0, i_rect_bottom = '0, i_rect_right = '0;
    logic [63:0] i_fill_pattern = '0;
    logic [14:0] i_byte_address = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_read_data;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mono_bitmap_pattern_fill u_top (.*);

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the engine state
    logic [7:0] shadow_fb [FB_SIZE];
    longint     clip_t = 0, clip_l = 0, clip_b = 512, clip_r = 512;

    t_cmd       pending_cmds [$];
    logic [7:0] expected_bytes [$];
    t_cmd       cur_cmd;
    int         send_idle_pct = 0, recv_stall_pct = 0;
    int         error_count = 0;
    int         idle_cycles = 0;

    function automatic logic [7:0] row_pattern(logic [63:0] pat, longint row);
        logic [2:0] idx;
        idx = row[2:0];
        return pat[{idx, 3'b000} +: 8];
    endfunction

    // Paint columns [x0,x1) of one row, clipped to clip region and screen
    function automatic void paint_span(longint row, longint x0, longint x1,
                                       logic [7:0] pb, bit do_xor);
        longint lo, hi, idx;
        logic [7:0] m_lo, m_hi, mask;
        if (row < clip_t || row >= clip_b || row < 0 || row >= SCR_H) return;
        if (x0 < clip_l) x0 = clip_l;
        if (x0 < 0) x0 = 0;
        if (x1 > clip_r) x1 = clip_r;
        if (x1 > SCR_W) x1 = SCR_W;
        if (x0 >= x1) return;
        for (longint b = x0 >>> 3; b <= (x1 - 1) >>> 3; b++) begin
            lo = x0 - b * 8;
            hi = x1 - b * 8;
            if (lo < 0) lo = 0;
            if (hi > 8) hi = 8;
            m_lo = 8'hFF >> lo;
            m_hi = 8'hFF >> hi;
            mask = m_lo & ~m_hi;
            idx = row * ROW_B + b;
            if (do_xor) shadow_fb[idx] = shadow_fb[idx] ^ (mask & pb);
            else        shadow_fb[idx] = (shadow_fb[idx] & ~mask) | (mask & pb);
        end
    endfunction

    function automatic void paint_ellipse(longint top, longint left, longint bottom,
                                          longint right, logic [63:0] pat);
        longint hw, hh_half, ox, oy, abs_w, hh, ww, hhww, prev_off, slope, off;
        hw = (right - left) / 2;
        hh_half = (bottom - top) / 2;
        ox = left + hw;
        oy = top + hh_half;
        abs_w = hw < 0 ? -hw : hw;
        hh = hh_half * hh_half;
        ww = hw * hw;
        hhww = hh * ww;
        prev_off = hw;
        slope = 0;
        paint_span(oy, left, right, row_pattern(pat, hh_half), 1'b0);
        for (longint row = 1; row <= hh_half; row++) begin
            if (oy - row < 0 && oy + row >= SCR_H) break;
            off = prev_off - (slope - 1);
            if (off > abs_w) off = abs_w;
            while (off > 0 && off * off * hh + row * row * ww > hhww) off--;
            paint_span(oy - row, ox - off, ox + off, row_pattern(pat, hh_half - row), 1'b0);
            paint_span(oy + row, ox - off, ox + off, row_pattern(pat, hh_half + row), 1'b0);
            slope = prev_off - off;
            prev_off = off;
        end
    endfunction

    // Apply one item to the shadow buffer, return the byte the engine must produce
    function automatic logic [7:0] apply_cmd(t_cmd c);
        longint t, l, b, r;
        t = c.top; l = c.left; b = c.bottom; r = c.right;
        case (c.op)
            mbpf_pkg::OP_RECT_COPY, mbpf_pkg::OP_RECT_XOR: begin
                for (longint row = (t < 0 ? 0 : t); row < (b > SCR_H ? SCR_H : b); row++)
                    paint_span(row, l, r, row_pattern(c.pat, row),
                               c.op == mbpf_pkg::OP_RECT_XOR);
                return 8'h00;
            end
            mbpf_pkg::OP_ELLIPSE: begin
                paint_ellipse(t, l, b, r, c.pat);
                return 8'h00;
            end
            default: return (c.addr < FB_SIZE) ? shadow_fb[c.addr] : 8'h00;
        endcase
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("MISMATCH %s: got %02h expected %02h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver: present the next pending item, predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) expected_bytes.push_back(apply_cmd(cur_cmd));
            if (!i_valid || !o_stall) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_cmd = pending_cmds.pop_front();
                    i_operation    <= cur_cmd.op;
                    i_rect_top     <= cur_cmd.top;
                    i_rect_left    <= cur_cmd.left;
                    i_rect_bottom  <= cur_cmd.bottom;
                    i_rect_right   <= cur_cmd.right;
                    i_fill_pattern <= cur_cmd.pat;
                    i_byte_address <= cur_cmd.addr;
                    i_valid        <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check results, random stall, idle watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_bytes.size() == 0) begin
                    report("unexpected result", o_read_data, 8'h00);
                end else begin
                    logic [7:0] want;
                    want = expected_bytes.pop_front();
                    if (o_read_data !== want) report("read_data", o_read_data, want);
                end
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("simulation failed");
                $finish;
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic write_clip(logic [1:0] regi, int value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {regi, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (regi)
            mbpf_pkg::REG_CLIP_TOP:    clip_t = value & 10'h3FF;
            mbpf_pkg::REG_CLIP_LEFT:   clip_l = value & 10'h3FF;
            mbpf_pkg::REG_CLIP_BOTTOM: clip_b = value & 10'h3FF;
            default:                   clip_r = value & 10'h3FF;
        endcase
    endtask

    task automatic set_clip(int t, int l, int b, int r);
        write_clip(mbpf_pkg::REG_CLIP_TOP, t);
        write_clip(mbpf_pkg::REG_CLIP_LEFT, l);
        write_clip(mbpf_pkg::REG_CLIP_BOTTOM, b);
        write_clip(mbpf_pkg::REG_CLIP_RIGHT, r);
    endtask

    task automatic push_cmd(mbpf_pkg::t_op op, int t, int l, int b, int r,
                            logic [63:0] pat, int addr);
        t_cmd c;
        c.op = op; c.top = 16'(t); c.left = 16'(l); c.bottom = 16'(b); c.right = 16'(r);
        c.pat = pat; c.addr = 15'(addr);
        pending_cmds.push_back(c);
    endtask

    // Wait until every item went in and every result came out
    task automatic drain();
        do @(posedge i_clk);
        while (pending_cmds.size() > 0 || i_valid || expected_bytes.size() > 0);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic int near_coord();
        return int'($urandom_range(180)) - 30;
    endfunction

    // One random item: mostly fills near the top-left window, reads biased there
    task automatic push_random();
        int sel, t, l, b, r, addr;
        logic [63:0] pat;
        sel = $urandom_range(99);
        pat = {$urandom, $urandom};
        t = near_coord(); l = near_coord();
        b = t + int'($urandom_range(60)) - 8;
        r = l + int'($urandom_range(90)) - 8;
        addr = ($urandom_range(1)) ? $urandom_range(32767)
                                   : $urandom_range(140) * ROW_B + $urandom_range(20);
        if (sel < 20) push_cmd(mbpf_pkg::OP_RECT_COPY, t, l, b, r, pat, addr);
        else if (sel < 35) push_cmd(mbpf_pkg::OP_RECT_XOR, t, l, b, r, pat, addr);
        else if (sel < 40) begin
            // full-range corners; clipping bounds the work
            push_cmd($urandom_range(1) ? mbpf_pkg::OP_RECT_XOR : mbpf_pkg::OP_RECT_COPY,
                     $signed(16'($urandom)), $signed(16'($urandom)),
                     $signed(16'($urandom)), $signed(16'($urandom)), pat, $urandom);
        end else if (sel < 55) push_cmd(mbpf_pkg::OP_ELLIPSE, t, l, b, r, pat, addr);
        else if (sel < 57) begin
            t = $urandom_range(560) - 40;
            l = $urandom_range(560) - 40;
            push_cmd(mbpf_pkg::OP_ELLIPSE, t, l, t + $urandom_range(500),
                     l + $urandom_range(600) - 50, pat, addr);
        end else push_cmd(mbpf_pkg::OP_READ, t, l, b, r, pat, addr);
    endtask

    initial begin
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 72, 0, 33};
        recv_pct = '{0, 0, 72, 33};
        foreach (shadow_fb[k]) shadow_fb[k] = 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, each operation, empty spans, odd ellipses
        push_cmd(mbpf_pkg::OP_READ, 0, 0, 0, 0, '0, 0);
        push_cmd(mbpf_pkg::OP_READ, 0, 0, 0, 0, '0, 15'h7FFF);
        push_cmd(mbpf_pkg::OP_RECT_COPY, -32768, -32768, 32767, 32767,
                 64'hFFFF_FFFF_FFFF_FFFF, 0);
        push_cmd(mbpf_pkg::OP_READ, 0, 0, 0, 0, '0, 15'h7FFF);
        push_cmd(mbpf_pkg::OP_RECT_XOR, -32768, -32768, 32767, 32767,
                 64'h0123_4567_89AB_CDEF, 0);
        push_cmd(mbpf_pkg::OP_READ, 0, 0, 0, 0, '0, 3 * ROW_B + 5);
        push_cmd(mbpf_pkg::OP_RECT_COPY, 10, 3, 20, 13, 64'hA5A5_5A5A_F00F_3CC3, 0);
        push_cmd(mbpf_pkg::OP_READ, 0, 0, 0, 0, '0, 12 * ROW_B);
        push_cmd(mbpf_pkg::OP_READ, 0, 0, 0, 0, '0, 12 * ROW_B + 1);
        push_cmd(mbpf_pkg::OP_RECT_COPY, 30, 30, 20, 40, '1, 0);   // inverted rows
        push_cmd(mbpf_pkg::OP_RECT_XOR, 5, 50, 9, 50, '1, 0);      // empty columns
        push_cmd(mbpf_pkg::OP_RECT_XOR, 100, 505, 110, 600, 64'h8181_8181_8181_8181, 0);
        push_cmd(mbpf_pkg::OP_READ, 0, 0, 0, 0, '0, 101 * ROW_B + 63);
        push_cmd(mbpf_pkg::OP_ELLIPSE, 40, 40, 57, 73, 64'hFF00_FF00_FF00_FF00, 0);
        push_cmd(mbpf_pkg::OP_READ, 0, 0, 0, 0, '0, 48 * ROW_B + 5);
        push_cmd(mbpf_pkg::OP_ELLIPSE, 60, 60, 55, 80, '1, 0);     // negative half height
        push_cmd(mbpf_pkg::OP_ELLIPSE, 70, 90, 80, 70, '1, 0);     // negative half width
        push_cmd(mbpf_pkg::OP_READ, 0, 0, 0, 0, '0, 57 * ROW_B + 8);
        push_cmd(mbpf_pkg::OP_ELLIPSE, -32768, -32768, 32767, 32767,
                 64'h1122_3344_5566_7788, 0);
        push_cmd(mbpf_pkg::OP_READ, 0, 0, 0, 0, '0, 0);
        push_cmd(mbpf_pkg::OP_ELLIPSE, 480, 480, 540, 540, '1, 0);
        push_cmd(mbpf_pkg::OP_READ, 0, 0, 0, 0, '0, 511 * ROW_B + 63);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_clip(0, 0, 512, 512);
                1: set_clip($urandom_range(60), $urandom_range(60),
                            60 + $urandom_range(100), 60 + $urandom_range(100));
                2: set_clip(512, 512, 0, 0);                  // empty clip region
                default: set_clip(7, 13, 509, 503);
            endcase
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            repeat (95) push_random();
            drain();
        end

        if (error_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

[files.f]
rtl/mbpf_pkg.sv
rtl/mbpf_mul.sv
rtl/mono_bitmap_pattern_fill.sv
tb/tb_top.sv
